// ===== hdl/alarm_word_edge_event_tracker_top_assert.svh =====
// assertion macros for the alarm word edge event tracker checker
// no dependencies; taken in by the checker file with `include
`ifndef ALARM_WORD_EDGE_EVENT_TRACKER_TOP_ASSERT_SVH
`define ALARM_WORD_EDGE_EVENT_TRACKER_TOP_ASSERT_SVH

// same-cycle implication, quiet while reset is asserted
`define AWET_ASSERT_IMPLY(name, clk, rst_n, cond, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("awet: same-cycle check failed");

// next-cycle implication, quiet while reset is asserted
`define AWET_ASSERT_NEXT(name, clk, rst_n, cond, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("awet: next-cycle check failed");

// next-cycle implication that also holds across reset
`define AWET_ASSERT_NEXT_ALWAYS(name, clk, cond, prop) \
  name: assert property (@(posedge clk) (cond) |=> (prop)) \
    else $error("awet: reset check failed");

`endif

// ===== hdl/awet_pkg.sv =====
// shared types and constants for the alarm word edge event tracker
// no dependencies; used by every module of the block
`default_nettype none

package awet_pkg;

  localparam int SLOT_W         = 6;
  localparam int WORD_W         = 32;
  localparam int TIME_W         = 32;
  localparam int BIT_IDX_W      = 5;
  localparam int ENTRY_MAX_W    = SLOT_W + 1;
  localparam int SLOT_LIMIT     = 1 << SLOT_W;
  localparam int VEHICLES_DEF   = 64;
  localparam int ALARM_BITS_DEF = 32;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic EV_BEGIN = 1'b0;
  localparam logic EV_END   = 1'b1;

  typedef struct packed {
    logic [SLOT_W-1:0] vehicle_slot;
    logic              alarm_kind;
    logic [WORD_W-1:0] alarm_word;
    logic [TIME_W-1:0] event_time;
  } in_item_t;

  typedef struct packed {
    logic                 event_kind;
    logic [BIT_IDX_W-1:0] alarm_bit;
    logic [TIME_W-1:0]    start_time;
    logic [TIME_W-1:0]    stop_time;
    logic                 last_event;
  } out_item_t;

  // one classified report waiting for the event sequencer
  typedef struct packed {
    logic [ENTRY_MAX_W-1:0] entry;
    logic [WORD_W-1:0]      word;
    logic [WORD_W-1:0]      changed;
    logic [TIME_W-1:0]      now;
  } job_t;

endpackage

`default_nettype wire

// ===== hdl/awet_front.sv =====
// front end: accepts reports, compares with the stored prior word, queues jobs
// depends on awet_pkg
`default_nettype none

module awet_front #(
  parameter int VEHICLES   = awet_pkg::VEHICLES_DEF,
  parameter int ALARM_BITS = awet_pkg::ALARM_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire awet_pkg::in_item_t in_data,
  input  wire logic               q_full,
  output logic                    q_push,
  output awet_pkg::job_t          q_job
);

  localparam int SLOTS   = (VEHICLES < awet_pkg::SLOT_LIMIT) ? VEHICLES : awet_pkg::SLOT_LIMIT;
  localparam int DEPTH   = 2 * SLOTS;
  localparam int ENTRY_W = $clog2(DEPTH);
  localparam logic [awet_pkg::WORD_W-1:0] MASK =
    awet_pkg::WORD_W'((64'd1 << ALARM_BITS) - 64'd1);

  typedef enum logic {ST_IDLE, ST_CMP} state_t;

  state_t                        state_r, state_nxt;
  logic [DEPTH-1:0]              valid_r, valid_nxt;
  logic [awet_pkg::WORD_W-1:0]   prior_mem [DEPTH];
  logic [awet_pkg::WORD_W-1:0]   prior_r;
  logic                          seen_r;
  logic [ENTRY_W-1:0]            entry_r;
  awet_pkg::in_item_t            item_r;

  logic [awet_pkg::ENTRY_MAX_W-1:0] entry_full;
  logic [ENTRY_W-1:0]               in_entry;
  logic                             slot_ok;
  logic                             accept;
  logic                             commit;
  logic [awet_pkg::WORD_W-1:0]      word_m;
  logic [awet_pkg::WORD_W-1:0]      changed;

  assign entry_full = {in_data.vehicle_slot, in_data.alarm_kind};
  assign in_entry   = entry_full[ENTRY_W-1:0];
  assign slot_ok    = {1'b0, in_data.vehicle_slot} < awet_pkg::ENTRY_MAX_W'(SLOTS);
  assign in_stall   = (state_r != ST_IDLE);
  assign accept     = in_valid && !in_stall;

  // words are stored masked, so an unwritten entry reads as zero via its valid bit
  assign word_m  = item_r.alarm_word & MASK;
  assign changed = word_m ^ (seen_r ? prior_r : '0);
  assign commit  = (state_r == ST_CMP) && !q_full;
  assign q_push  = commit && (changed != '0);

  always_comb begin
    q_job.entry   = awet_pkg::ENTRY_MAX_W'(entry_r);
    q_job.word    = word_m;
    q_job.changed = changed;
    q_job.now     = item_r.event_time;
  end

  always_comb begin
    state_nxt = state_r;
    valid_nxt = valid_r;
    case (state_r)
      ST_IDLE: begin
        // out-of-range slots are taken and dropped
        if (accept && slot_ok) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (commit) begin
          valid_nxt[entry_r] = 1'b1;
          state_nxt          = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prior_r <= prior_mem[in_entry];
      seen_r  <= valid_r[in_entry];
      entry_r <= in_entry;
      item_r  <= in_data;
    end
    if (commit) begin
      prior_mem[entry_r] <= word_m;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/awet_queue.sv =====
// short job queue between the front end and the event sequencer
// depends on awet_pkg
`default_nettype none

module awet_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire awet_pkg::job_t push_job,
  output logic                full,
  input  wire logic           pop,
  output awet_pkg::job_t      pop_job,
  output logic                empty
);

  localparam int PTR_W = (awet_pkg::QUEUE_DEPTH > 1) ? $clog2(awet_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(awet_pkg::QUEUE_DEPTH + 1);

  awet_pkg::job_t     slot_r [awet_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(awet_pkg::QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(awet_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(awet_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/awet_back.sv =====
// back end: walks the changed bits of a job, keeps begin times, drives events
// depends on awet_pkg
`default_nettype none

module awet_back #(
  parameter int VEHICLES   = awet_pkg::VEHICLES_DEF,
  parameter int ALARM_BITS = awet_pkg::ALARM_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  output logic                q_pop,
  input  wire awet_pkg::job_t q_job,
  output logic                out_valid,
  input  wire logic           out_stall,
  output awet_pkg::out_item_t out_data
);

  localparam int SLOTS   = (VEHICLES < awet_pkg::SLOT_LIMIT) ? VEHICLES : awet_pkg::SLOT_LIMIT;
  localparam int ENTRY_W = $clog2(2 * SLOTS);
  localparam int DEPTH   = 2 * SLOTS * ALARM_BITS;
  localparam int TIX_W   = $clog2(DEPTH);
  localparam int BIT_W   = (ALARM_BITS > 1) ? $clog2(ALARM_BITS) : 1;

  // begin times are only read for a falling bit, whose rise always wrote them first
  logic [awet_pkg::TIME_W-1:0] time_mem [DEPTH];

  logic [ALARM_BITS-1:0]       mask_r, mask_nxt;
  logic [ALARM_BITS-1:0]       word_r;
  logic [ENTRY_W-1:0]          entry_r;
  logic [awet_pkg::TIME_W-1:0] now_r;

  logic                        p_valid_r, p_valid_nxt;
  logic                        p_kind_r;
  logic [BIT_W-1:0]            p_bit_r;
  logic [awet_pkg::TIME_W-1:0] p_now_r;
  logic                        p_last_r;
  logic [awet_pkg::TIME_W-1:0] rd_r;

  logic                        out_valid_r, out_valid_nxt;
  awet_pkg::out_item_t         out_data_r, out_data_nxt;

  logic [ALARM_BITS-1:0]       low;
  logic [ALARM_BITS-1:0]       rest;
  logic [BIT_W-1:0]            bit_idx;
  logic                        rising;
  logic [TIX_W-1:0]            tix;
  logic                        busy, out_free, p_move, p_free, issue;

  // isolate the lowest pending bit and encode its index
  always_comb begin
    low     = mask_r & (~mask_r + ALARM_BITS'(1));
    rest    = mask_r & ~low;
    bit_idx = '0;
    for (int i = 0; i < ALARM_BITS; i++) begin
      if (low[i]) begin
        bit_idx = bit_idx | BIT_W'(i);
      end
    end
  end

  assign rising   = |(word_r & low);
  assign tix      = TIX_W'(entry_r) * TIX_W'(ALARM_BITS) + TIX_W'(bit_idx);
  assign busy     = |mask_r;
  assign out_free = !out_valid_r || !out_stall;
  assign p_move   = p_valid_r && out_free;
  assign p_free   = !p_valid_r || p_move;
  assign issue    = busy && p_free;
  assign q_pop    = !busy && !q_empty;

  always_comb begin
    mask_nxt = mask_r;
    if (q_pop) begin
      mask_nxt = q_job.changed[ALARM_BITS-1:0];
    end else if (issue) begin
      mask_nxt = rest;
    end
  end

  always_comb begin
    p_valid_nxt = p_valid_r;
    if (issue) begin
      p_valid_nxt = 1'b1;
    end else if (p_move) begin
      p_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_data_nxt.event_kind = p_kind_r;
    out_data_nxt.alarm_bit  = awet_pkg::BIT_IDX_W'(p_bit_r);
    out_data_nxt.start_time = (p_kind_r == awet_pkg::EV_END) ? rd_r : p_now_r;
    out_data_nxt.stop_time  = (p_kind_r == awet_pkg::EV_END) ? p_now_r : '0;
    out_data_nxt.last_event = p_last_r;
    out_valid_nxt = out_valid_r;
    if (p_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      word_r  <= q_job.word[ALARM_BITS-1:0];
      entry_r <= q_job.entry[ENTRY_W-1:0];
      now_r   <= q_job.now;
    end
    if (issue) begin
      p_kind_r <= rising ? awet_pkg::EV_BEGIN : awet_pkg::EV_END;
      p_bit_r  <= bit_idx;
      p_now_r  <= now_r;
      p_last_r <= (rest == '0);
      if (rising) begin
        time_mem[tix] <= now_r;
      end else begin
        rd_r <= time_mem[tix];
      end
    end
    if (p_move) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== hdl/alarm_word_edge_event_tracker_top.sv =====
// Alarm word edge event tracker. Each report (vehicle slot, word kind, alarm word,
// timestamp) is compared with the word last stored for that slot and kind, and one
// event leaves for every bit that changed, lowest bit first: a rising bit records
// its begin time and gives a begin event (stop_time 0), a falling bit gives an end
// event carrying the recorded begin time and the report time. last_event marks the
// final event of a report; a report with no change or an out-of-range slot gives
// none. The front end reads the prior word of a report, then compares and writes
// it back, waiting while the queue is full, and hands the job through a two-entry
// job queue to the event sequencer, which loads each job and then emits one event
// per cycle while the output is not stalled, bounded by the single port of the
// begin-time memory; a report gives at most ALARM_BITS events. Reset clears the
// valid bits, the queue and all control state; the memories need no clearing pass.
// depends on awet_pkg, awet_front, awet_queue, awet_back
`default_nettype none

module alarm_word_edge_event_tracker_top #(
  parameter int VEHICLES   = awet_pkg::VEHICLES_DEF,
  parameter int ALARM_BITS = awet_pkg::ALARM_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire awet_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output awet_pkg::out_item_t      out_data
);

  logic           q_push, q_full, q_pop, q_empty;
  awet_pkg::job_t push_job, pop_job;

  awet_front #(
    .VEHICLES   (VEHICLES),
    .ALARM_BITS (ALARM_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  awet_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  awet_back #(
    .VEHICLES   (VEHICLES),
    .ALARM_BITS (ALARM_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_job     (pop_job),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== hdl/awet_checker.sv =====
// port-level checks on the event output of the tracker, bound to the top level
// depends on awet_pkg and alarm_word_edge_event_tracker_top_assert.svh
`default_nettype none
`include "alarm_word_edge_event_tracker_top_assert.svh"

module awet_checker #(
  parameter int ALARM_BITS = awet_pkg::ALARM_BITS_DEF
) (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire awet_pkg::out_item_t out_data
);

  // a stalled transaction stays put
  `AWET_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

  `AWET_ASSERT_IMPLY(a_begin_stop_zero, clk, rst_n, out_valid && out_data.event_kind == awet_pkg::EV_BEGIN, out_data.stop_time == '0)

  `AWET_ASSERT_IMPLY(a_bit_range, clk, rst_n, out_valid, {1'b0, out_data.alarm_bit} < 6'(ALARM_BITS))

  `AWET_ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, !rst_n, !out_valid)

endmodule

bind alarm_word_edge_event_tracker_top awet_checker #(
  .ALARM_BITS (ALARM_BITS)
) u_awet_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ===== tb/alarm_word_edge_event_tracker_checker.sv =====
// checker for the alarm word edge event tracker: watches both channels, keeps its own
// copy of the stored words and begin times, and compares every event leaving the block
// depends on awet_pkg
`default_nettype none

module alarm_word_edge_event_tracker_checker
  import awet_pkg::*;
#(
  parameter int VEHICLES   = VEHICLES_DEF,
  parameter int ALARM_BITS = ALARM_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_stall,
  input  wire in_item_t  in_data,
  input  wire logic      out_valid,
  input  wire logic      out_stall,
  input  wire out_item_t out_data,
  output int             fail_count,
  output int             events_pending
);

  localparam int ENTRIES = VEHICLES * 2;
  localparam logic [WORD_W-1:0] ALARM_MASK = {WORD_W{1'b1}} >> (WORD_W - ALARM_BITS);

  logic [WORD_W-1:0] prior_word_mem [ENTRIES];
  logic [TIME_W-1:0] begin_time_mem [ENTRIES*ALARM_BITS];
  out_item_t         expected_events [$];
  int                fails = 0;

  // one event per changed bit, lowest first; the last one of the report is flagged
  function automatic void track_report(in_item_t rpt);
    int unsigned       entry;
    int unsigned       tix;
    int                n_events;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] changed;
    out_item_t         ev;
    if (rpt.vehicle_slot >= VEHICLES) return;
    entry    = rpt.vehicle_slot * 2 + rpt.alarm_kind;
    word     = rpt.alarm_word & ALARM_MASK;
    changed  = (word ^ prior_word_mem[entry]) & ALARM_MASK;
    n_events = 0;
    for (int b = 0; b < ALARM_BITS; b++) begin
      if (changed[b]) begin
        tix           = entry * ALARM_BITS + b;
        ev.alarm_bit  = BIT_IDX_W'(b);
        ev.last_event = 1'b0;
        if (word[b]) begin
          ev.event_kind       = EV_BEGIN;
          ev.start_time       = rpt.event_time;
          ev.stop_time        = '0;
          begin_time_mem[tix] = rpt.event_time;
        end else begin
          ev.event_kind       = EV_END;
          ev.start_time       = begin_time_mem[tix];
          ev.stop_time        = rpt.event_time;
          begin_time_mem[tix] = '0;
        end
        expected_events.insert(expected_events.size(), ev);
        n_events++;
      end
    end
    if (n_events > 0) begin
      expected_events[expected_events.size() - 1].last_event = 1'b1;
    end
    prior_word_mem[entry] = word;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      foreach (prior_word_mem[i]) prior_word_mem[i] = '0;
      foreach (begin_time_mem[i]) begin_time_mem[i] = '0;
      expected_events.delete();
    end else begin
      // input side first so a transaction's events are queued before any can leave
      if (in_valid && !in_stall) track_report(in_data);
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          $error("unexpected event: event_kind %0d alarm_bit %0d start_time %0h stop_time %0h",
                 out_data.event_kind, out_data.alarm_bit, out_data.start_time,
                 out_data.stop_time);
          fails++;
        end else begin
          want = expected_events.pop_front();
          if (out_data.event_kind !== want.event_kind) begin
            $error("event_kind: expected %0d, got %0d", want.event_kind, out_data.event_kind);
            fails++;
          end
          if (out_data.alarm_bit !== want.alarm_bit) begin
            $error("alarm_bit: expected %0d, got %0d", want.alarm_bit, out_data.alarm_bit);
            fails++;
          end
          if (out_data.start_time !== want.start_time) begin
            $error("start_time: expected %0h, got %0h", want.start_time, out_data.start_time);
            fails++;
          end
          if (out_data.stop_time !== want.stop_time) begin
            $error("stop_time: expected %0h, got %0h", want.stop_time, out_data.stop_time);
            fails++;
          end
          if (out_data.last_event !== want.last_event) begin
            $error("last_event: expected %0d, got %0d", want.last_event, out_data.last_event);
            fails++;
          end
        end
      end
    end
    events_pending <= expected_events.size();
    fail_count     <= fails;
  end

endmodule

`default_nettype wire

// ===== tb/alarm_word_edge_event_tracker_top_tb.sv =====
// testbench top for the alarm word edge event tracker: drives reports and random stalls,
// runs a directed part then random phases with varied idling and stalling, and gives the verdict
// depends on awet_pkg, alarm_word_edge_event_tracker_top and alarm_word_edge_event_tracker_checker
`default_nettype none

module alarm_word_edge_event_tracker_top_tb;
  import awet_pkg::*;

  localparam int RANDOM_REPORTS = 170;
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int SETTLE_CYCLES  = 100;
  localparam int PHASES         = 4;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int fail_count;
  int events_pending;
  int cycle_count = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;

  int idle_plan  [PHASES] = '{0, 88, 0, 23};
  int stall_plan [PHASES] = '{0, 0, 88, 23};

  // last word sent per slot and kind, only used to shape the stimulus
  logic [WORD_W-1:0] sent_words [VEHICLES_DEF*2];

  alarm_word_edge_event_tracker_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  alarm_word_edge_event_tracker_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .events_pending (events_pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  task automatic send_report(input logic [SLOT_W-1:0] slot, input logic kind,
                             input logic [WORD_W-1:0] word, input logic [TIME_W-1:0] stamp);
    in_item_t rpt;
    rpt.vehicle_slot = slot;
    rpt.alarm_kind   = kind;
    rpt.alarm_word   = word;
    rpt.event_time   = stamp;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= rpt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_words[{slot, kind}] = word;
  endtask

  // lower in_valid and let the checker see the last transaction before polling the count
  task automatic wait_for_events();
    in_valid <= 1'b0;
    @(posedge clk);
    while (events_pending != 0) @(posedge clk);
  endtask

  // often one to three flipped bits so begin times get picked up again by a later end
  function automatic logic [WORD_W-1:0] next_word(input logic [WORD_W-1:0] prior);
    logic [WORD_W-1:0] flips;
    logic [WORD_W-1:0] word;
    flips = '0;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        repeat ($urandom_range(3, 1)) flips[$urandom_range(WORD_W-1)] = 1'b1;
        word = prior ^ flips;
      end
      4, 5:    word = prior ^ ($urandom & $urandom);
      6:       word = prior;
      7:       word = $urandom;
      8:       word = '0;
      default: word = '1;
    endcase
    return word;
  endfunction

  initial begin : stimulus
    logic [SLOT_W-1:0] slot;
    logic              kind;
    logic [TIME_W-1:0] stamp;
    foreach (sent_words[i]) sent_words[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every bit rises, then every bit falls carrying the all-ones begin time
    send_report(6'd0, 1'b0, '1, '1);
    send_report(6'd0, 1'b0, '0, 32'd5);
    send_report(6'd0, 1'b0, '0, 32'd7);
    // top slot, second table; an alarm that began at time zero ends with start 0
    send_report(6'd63, 1'b1, 32'h8000_0001, 32'd0);
    send_report(6'd63, 1'b1, 32'h0000_0001, 32'h1234_5678);
    send_report(6'd63, 1'b0, 32'h8000_0000, '1);
    send_report(6'd63, 1'b1, 32'h0000_0000, 32'd9);
    send_report(6'd21, 1'b0, 32'hAAAA_AAAA, 32'd100);
    send_report(6'd21, 1'b0, 32'h5555_5555, 32'd200);
    send_report(6'd21, 1'b0, 32'hAAAA_AAAA, 32'd300);
    send_report(6'd21, 1'b1, '1, '1);
    send_report(6'd21, 1'b1, '1, 32'd0);
    send_report(6'd42, 1'b0, 32'h0001_0000, 32'd1);
    send_report(6'd42, 1'b0, 32'h0000_0000, 32'd2);
    send_report(6'd63, 1'b0, 32'h0000_0000, 32'hFFFF_FFFE);
    wait_for_events();

    for (int ph = 0; ph < PHASES; ph++) begin
      idle_pct  = idle_plan[ph];
      stall_pct <= stall_plan[ph];
      repeat (RANDOM_REPORTS / PHASES) begin
        // most reports revisit a handful of slots so falling edges are common
        slot  = ($urandom_range(3) != 0) ? SLOT_W'($urandom_range(3)) : SLOT_W'($urandom_range(63));
        kind  = 1'($urandom_range(1));
        case ($urandom_range(9))
          0:       stamp = '0;
          1:       stamp = '1;
          default: stamp = $urandom;
        endcase
        send_report(slot, kind, next_word(sent_words[{slot, kind}]), stamp);
      end
      wait_for_events();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
